FILE: src/hcbp_pkg.sv
// Shared types and constants of the code bit packer.
`timescale 1ns / 1ps
`default_nettype none

package hcbp_pkg;

    // Item actions
    localparam logic [1:0] ACT_LOAD   = 2'd0;
    localparam logic [1:0] ACT_ENCODE = 2'd1;
    localparam logic [1:0] ACT_FLUSH  = 2'd2;

    // Field widths
    localparam int ACT_W  = 2;
    localparam int SYM_W  = 8;
    localparam int LEN_W  = 6;
    localparam int CODE_W = 32;
    localparam int BYTE_W = 8;
    localparam int PEND_W = 7;
    localparam int CNT_W  = 3;

    // Merged bit string: up to seven pending bits plus one full code
    localparam int MERGE_W = PEND_W + CODE_W;
    // Left-justified output word, whole bytes
    localparam int WORD_W  = 40;
    localparam int NBYTE_W = 3;

    // Code table entry: length above bits
    localparam int ENTRY_W = LEN_W + CODE_W;
    localparam int TABLE_DEPTH = 256;

    // Bytes handed to the output shifter
    typedef struct packed {
        logic               load;
        logic [WORD_W-1:0]  word;
        logic [NBYTE_W-1:0] nbytes;
    } t_pack_load;

endpackage

`default_nettype wire

FILE: src/hcbp_if.sv
// Valid/ready channel interfaces for input and result items.
`timescale 1ns / 1ps
`default_nettype none

interface hcbp_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [7:0]  symbol;
    logic [5:0]  code_length;
    logic [31:0] code_bits;

    modport source (output valid, action, symbol, code_length, code_bits, input ready);
    modport sink   (input valid, action, symbol, code_length, code_bits, output ready);
endinterface

interface hcbp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] packed_byte;
    logic       last;

    modport source (output valid, packed_byte, last, input ready);
    modport sink   (input valid, packed_byte, last, output ready);
endinterface

`default_nettype wire

FILE: src/hcbp_ram.sv
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
`default_nettype none

module hcbp_ram #(
    parameter int WIDTH = 38,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write one entry, read one entry into the output register
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

FILE: src/hcbp_out_shifter.sv
// Output byte shifter: drains a left-justified word one byte per item.
`timescale 1ns / 1ps
`default_nettype none

module hcbp_out_shifter (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire hcbp_pkg::t_pack_load i_load,
    output logic                     o_busy,
    hcbp_out_if.source               o_out
);
    import hcbp_pkg::*;

    logic [WORD_W-1:0]  r_word;
    logic [WORD_W-1:0]  n_word;
    logic [NBYTE_W-1:0] r_left;
    logic [NBYTE_W-1:0] n_left;
    logic               out_take;

    assign out_take          = o_out.valid && o_out.ready;
    assign o_out.valid       = (r_left != '0);
    assign o_out.packed_byte = r_word[WORD_W-1 -: BYTE_W];
    assign o_out.last        = (r_left == NBYTE_W'(1));
    assign o_busy            = o_out.valid;

    // Load a new word, or advance by one byte on each taken item
    always_comb begin
        n_word = r_word;
        n_left = r_left;
        if (i_load.load) begin
            n_word = i_load.word;
            n_left = i_load.nbytes;
        end else if (out_take) begin
            n_word = r_word << BYTE_W;
            n_left = r_left - NBYTE_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
        end else begin
            r_left <= n_left;
        end
        r_word <= n_word;
    end

    // A new word never lands on bytes still waiting
    a_load_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load.load |-> (r_left == '0))
        else $error("output word loaded while bytes pending");

    // Byte count only falls by one per taken item
    a_left_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_take && !i_load.load) |=> (r_left == $past(r_left) - NBYTE_W'(1)))
        else $error("byte count skipped");

endmodule

`default_nettype wire

FILE: src/huffman_code_bit_packer.sv
// Top level: code table RAM, bit merge and byte output of the packer.
// Load item: written to the code table at acceptance.
// Encode item: table read in the accept cycle, merge in the next, then one
//   byte per cycle while the output is ready (0 to 4 bytes); next item taken
//   after the last byte leaves.
// Flush item: one zero-padded byte goes out if bits were pending.
// Reset (synchronous, active low) empties the pending bits; table is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module huffman_code_bit_packer #(
    parameter int MAX_CODE_LEN = 32
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    hcbp_in_if.sink    i_in,
    hcbp_out_if.source o_out
);
    import hcbp_pkg::*;

    localparam int LenLimInt = (MAX_CODE_LEN > CODE_W) ? CODE_W : MAX_CODE_LEN;
    localparam logic [LEN_W-1:0] LenLim = LEN_W'(LenLimInt);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_LOOK = 1'b1;

    logic               r_state;
    logic               n_state;
    logic [PEND_W-1:0]  r_pend;
    logic [PEND_W-1:0]  n_pend;
    logic [CNT_W-1:0]   r_cnt;
    logic [CNT_W-1:0]   n_cnt;

    logic               in_take;
    logic               out_busy;
    logic [LEN_W-1:0]   wr_len;
    logic [ENTRY_W-1:0] rd_entry;
    logic [LEN_W-1:0]   rd_len;
    logic [CODE_W-1:0]  rd_code;
    logic [CODE_W:0]    code_mask;
    logic [MERGE_W-1:0] merged;
    logic [LEN_W-1:0]   total;
    logic [LEN_W-1:0]   just_sh;
    logic [PEND_W-1:0]  rem_mask;
    logic [BYTE_W-1:0]  flush_byte;
    t_pack_load         pack_load;

    assign i_in.ready = (r_state == S_IDLE) && !out_busy;
    assign in_take    = i_in.valid && i_in.ready;

    // Saturate the loaded length
    assign wr_len = (i_in.code_length > LenLim) ? LenLim : i_in.code_length;

    hcbp_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (in_take && (i_in.action == ACT_LOAD)),
        .i_waddr (i_in.symbol),
        .i_wdata ({wr_len, i_in.code_bits}),
        .i_re    (in_take && (i_in.action == ACT_ENCODE)),
        .i_raddr (i_in.symbol),
        .o_rdata (rd_entry)
    );

    assign rd_len  = rd_entry[ENTRY_W-1 -: LEN_W];
    assign rd_code = rd_entry[CODE_W-1:0];

    // Append the code to the pending bits, then left-justify the string
    assign code_mask = ((CODE_W+1)'(1) << rd_len) - (CODE_W+1)'(1);
    assign merged    = (MERGE_W'(r_pend) << rd_len)
                     | MERGE_W'(rd_code & code_mask[CODE_W-1:0]);
    assign total     = LEN_W'(r_cnt) + rd_len;
    assign just_sh   = LEN_W'(WORD_W) - total;
    assign rem_mask  = (PEND_W'(1) << total[CNT_W-1:0]) - PEND_W'(1);

    // Zero-pad the pending bits up to a byte
    assign flush_byte = BYTE_W'({1'b0, r_pend} << (4'(BYTE_W) - {1'b0, r_cnt}));

    // Steer the next state, pending bits and output load
    always_comb begin
        n_state          = r_state;
        n_pend           = r_pend;
        n_cnt            = r_cnt;
        pack_load.load   = 1'b0;
        pack_load.word   = (WORD_W'(merged) << just_sh);
        pack_load.nbytes = total[LEN_W-1:CNT_W];
        unique case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    priority if (i_in.action == ACT_ENCODE) begin
                        n_state = S_LOOK;
                    end else if (i_in.action == ACT_FLUSH) begin
                        n_pend = '0;
                        n_cnt  = '0;
                        if (r_cnt != '0) begin
                            pack_load.load   = 1'b1;
                            pack_load.word   = {flush_byte, {(WORD_W-BYTE_W){1'b0}}};
                            pack_load.nbytes = NBYTE_W'(1);
                        end
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_LOOK: begin
                n_state        = S_IDLE;
                pack_load.load = 1'b1;
                n_pend         = merged[PEND_W-1:0] & rem_mask;
                n_cnt          = total[CNT_W-1:0];
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pend  <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
            r_cnt   <= n_cnt;
        end
    end

    hcbp_out_shifter u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (pack_load),
        .o_busy  (out_busy),
        .o_out   (o_out)
    );

    // Merge only runs with the output side empty
    a_look_idle_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOOK) |-> !out_busy)
        else $error("merge while output busy");

    // Pending bits above the count stay clear
    a_pend_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_pend >> r_cnt) == '0))
        else $error("stray pending bits");

    // An encode item goes to the merge step next cycle
    a_encode_look: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_take && (i_in.action == ACT_ENCODE)) |=> (r_state == S_LOOK))
        else $error("encode did not reach merge");

endmodule

`default_nettype wire
